/* rtl/core/ircc_pkg.sv */
// ----------------------------------------------------------------------------
// ircc_pkg
// Shared types and constants of the image report chunker: header layout,
// register indexes and the entry that travels from the front to the back.
// ----------------------------------------------------------------------------
package ircc_pkg;

    localparam int PAYLOAD_BYTES = 1016;
    localparam int LEN_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int HDR_BYTES     = 8;
    localparam int STEP_W        = $clog2(HDR_BYTES + 1);
    localparam int HPOS_W        = $clog2(HDR_BYTES);

    localparam int KEY_W   = 4;
    localparam int SIZE_W  = 16;
    localparam int PAGE_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [BYTE_W-1:0] REPORT_ID = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_IMAGE = 8'h07;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_KEY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE = 2'd1;

    localparam logic [HPOS_W-1:0] HB_REPORT_ID = 3'd0;
    localparam logic [HPOS_W-1:0] HB_COMMAND   = 3'd1;
    localparam logic [HPOS_W-1:0] HB_KEY       = 3'd2;
    localparam logic [HPOS_W-1:0] HB_LAST      = 3'd3;
    localparam logic [HPOS_W-1:0] HB_LEN_LO    = 3'd4;
    localparam logic [HPOS_W-1:0] HB_LEN_HI    = 3'd5;
    localparam logic [HPOS_W-1:0] HB_PAGE_LO   = 3'd6;
    localparam logic [HPOS_W-1:0] HB_PAGE_HI   = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              hdr;
        logic              hdr_last;
        logic [LEN_W-1:0]  len;
        logic [PAGE_W-1:0] page;
        logic [KEY_W-1:0]  key;
        logic              cend;
        logic              iend;
    } ircc_entry_t;

    typedef struct packed {
        logic        valid;
        ircc_entry_t entry;
    } ircc_slot_t;

endpackage

/* rtl/core/ircc_front.sv */
// ----------------------------------------------------------------------------
// ircc_front
// Accepts image bytes, tracks image offset, chunk position and page count,
// and classifies each byte: dropped, plain payload, or chunk opener.
// ----------------------------------------------------------------------------
module ircc_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ircc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ircc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ircc_pkg::BYTE_W-1:0]       s_image_byte,
    input  logic                              q_full,
    output ircc_pkg::ircc_slot_t              q_push
);
    import ircc_pkg::*;

    logic [KEY_W-1:0]  key_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] offset_reg, offset_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;

    logic              accept;
    logic              drop;
    logic [SIZE_W-1:0] remaining;
    logic [LEN_W-1:0]  len;
    logic              hdr_last;
    logic [SIZE_W:0]   offset_inc;
    logic              iend;
    logic              cend;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;

    always_comb begin
        drop       = (size_reg == '0) || (offset_reg >= size_reg);
        remaining  = size_reg - offset_reg;
        hdr_last   = remaining <= SIZE_W'(PAYLOAD_BYTES);
        len        = hdr_last ? remaining[LEN_W-1:0] : LEN_W'(PAYLOAD_BYTES);
        offset_inc = {1'b0, offset_reg} + (SIZE_W+1)'(1);
        iend       = offset_inc >= {1'b0, size_reg};
        cend       = iend || (pos_reg >= LEN_W'(PAYLOAD_BYTES - 1));
    end

    always_comb begin
        offset_next = offset_reg;
        page_next   = page_reg;
        pos_next    = pos_reg;
        if (accept) begin
            if (drop || iend) begin
                offset_next = '0;
                page_next   = '0;
                pos_next    = '0;
            end else begin
                offset_next = offset_inc[SIZE_W-1:0];
                if (cend) begin
                    pos_next  = '0;
                    page_next = page_reg + PAGE_W'(1);
                end else begin
                    pos_next = pos_reg + LEN_W'(1);
                end
            end
        end
    end

    always_comb begin
        q_push.valid          = accept && !drop;
        q_push.entry.data     = s_image_byte;
        q_push.entry.hdr      = pos_reg == '0;
        q_push.entry.hdr_last = hdr_last;
        q_push.entry.len      = len;
        q_push.entry.page     = page_reg;
        q_push.entry.key      = key_reg;
        q_push.entry.cend     = cend;
        q_push.entry.iend     = iend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg    <= '0;
            size_reg   <= '0;
            offset_reg <= '0;
            page_reg   <= '0;
            pos_reg    <= '0;
        end else begin
            offset_reg <= offset_next;
            page_reg   <= page_next;
            pos_reg    <= pos_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_TARGET_KEY) begin
                    key_reg <= cfg_data[KEY_W-1:0];
                end else if (cfg_index == REG_IMAGE_SIZE) begin
                    size_reg <= cfg_data[SIZE_W-1:0];
                end
            end
        end
    end

endmodule

/* rtl/core/ircc_queue.sv */
// ----------------------------------------------------------------------------
// ircc_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module ircc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ircc_pkg::ircc_slot_t push,
    output logic                 full,
    output ircc_pkg::ircc_slot_t head,
    input  logic                 pop
);
    import ircc_pkg::*;

    ircc_entry_t       mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = count_reg == QCNT_W'(QDEPTH);
    assign head.valid = count_reg != '0;
    assign head.entry = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != QCNT_W'(QDEPTH) && count_reg != '0) |->
            (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - QCNT_W'(1)))
        else $error("queue count did not follow pop");
`endif

endmodule

/* rtl/core/ircc_back.sv */
// ----------------------------------------------------------------------------
// ircc_back
// Expands each queued item into its header bytes and payload byte and
// holds them in the output register until the receiver takes them.
// ----------------------------------------------------------------------------
module ircc_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ircc_pkg::ircc_slot_t         head,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ircc_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                         m_report_start,
    output logic                         m_chunk_end,
    output logic                         m_image_end,
    output logic                         m_run_last
);
    import ircc_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              start_reg, start_next;
    logic              cend_reg, cend_next;
    logic              iend_reg, iend_next;
    logic              last_reg, last_next;

    logic              free;
    logic              fire;
    logic              emit_payload;
    logic [BYTE_W-1:0] hdr_byte;
    logic [15:0]       len_ext;

    assign free         = !valid_reg || m_ready;
    assign fire         = head.valid && free;
    assign emit_payload = !head.entry.hdr || (step_reg == STEP_W'(HDR_BYTES));
    assign pop          = fire && emit_payload;
    assign len_ext      = 16'(head.entry.len);

    always_comb begin
        unique case (step_reg[HPOS_W-1:0])
            HB_REPORT_ID: hdr_byte = REPORT_ID;
            HB_COMMAND:   hdr_byte = CMD_IMAGE;
            HB_KEY:       hdr_byte = BYTE_W'(head.entry.key);
            HB_LAST:      hdr_byte = BYTE_W'(head.entry.hdr_last);
            HB_LEN_LO:    hdr_byte = len_ext[7:0];
            HB_LEN_HI:    hdr_byte = len_ext[15:8];
            HB_PAGE_LO:   hdr_byte = head.entry.page[7:0];
            HB_PAGE_HI:   hdr_byte = head.entry.page[15:8];
            default:      hdr_byte = '0;
        endcase
    end

    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        start_next = start_reg;
        cend_next  = cend_reg;
        iend_next  = iend_reg;
        last_next  = last_reg;
        if (free) begin
            valid_next = fire;
        end
        if (fire) begin
            if (emit_payload) begin
                step_next  = '0;
                byte_next  = head.entry.data;
                start_next = 1'b0;
                cend_next  = head.entry.cend;
                iend_next  = head.entry.iend;
                last_next  = 1'b1;
            end else begin
                step_next  = step_reg + STEP_W'(1);
                byte_next  = hdr_byte;
                start_next = step_reg == '0;
                cend_next  = 1'b0;
                iend_next  = 1'b0;
                last_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        start_reg <= start_next;
        cend_reg  <= cend_next;
        iend_reg  <= iend_next;
        last_reg  <= last_next;
    end

    assign m_valid        = valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_report_start = start_reg;
    assign m_chunk_end    = cend_reg;
    assign m_image_end    = iend_reg;
    assign m_run_last     = last_reg;

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_W'(HDR_BYTES))
        else $error("header step out of range");

    a_start_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && start_reg) |-> !last_reg)
        else $error("report start on a payload byte");

    a_iend_cend: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && iend_reg) |-> (cend_reg && last_reg))
        else $error("image end without chunk end");

    a_step_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (step_reg == '0))
        else $error("header step not cleared after payload byte");
`endif

endmodule

/* rtl/core/image_report_chunker_core.sv */
// ----------------------------------------------------------------------------
// image_report_chunker_core
// Splits an image byte stream into reports of an 8-byte header followed by
// up to 1016 payload bytes.
//
// Configuration: cfg_index 0 writes the key index, 1 the image size in bytes;
// write only while the block is idle. cfg_ready is always high.
// Input: one image byte per s_valid/s_ready handshake. Bytes beyond the
// image size are dropped and restart the progress counters.
// Output: one report byte per m_valid/m_ready handshake, tagged with report
// start, chunk end, image end and the last-result-of-this-byte flag.
// An accepted byte is written into the queue and is then loaded into the
// output register when that register is free, which raises m_valid.
// Throughput: one result per cycle while m_ready is high; a chunk opener
// gives nine results, any other byte one, so the output side sets the pace.
// A four-entry queue decouples input from header expansion; s_ready falls
// only when it is full. A stalled receiver holds the output register and
// fills the queue. Reset clears the registers, counters, queue and output.
// ----------------------------------------------------------------------------
module image_report_chunker_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ircc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ircc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ircc_pkg::BYTE_W-1:0]       s_image_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ircc_pkg::BYTE_W-1:0]       m_out_byte,
    output logic                              m_report_start,
    output logic                              m_chunk_end,
    output logic                              m_image_end,
    output logic                              m_run_last
);
    import ircc_pkg::*;

    ircc_slot_t q_push;
    ircc_slot_t q_head;
    logic       q_full;
    logic       q_pop;

    ircc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_image_byte (s_image_byte),
        .q_full       (q_full),
        .q_push       (q_push)
    );

    ircc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .full    (q_full),
        .head    (q_head),
        .pop     (q_pop)
    );

    ircc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (q_head),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_report_start (m_report_start),
        .m_chunk_end    (m_chunk_end),
        .m_image_end    (m_image_end),
        .m_run_last     (m_run_last)
    );

endmodule

/* test/tb_image_report_chunker_core.sv */
// ----------------------------------------------------------------------------
// tb_image_report_chunker_core
// Self-checking bench for the image report chunker. A directed table covers
// reset, empty and one-byte images, the largest key and size, a size lowered
// under the offset and the unused register indexes. Random images of mostly
// small sizes follow, with broken and overrun images, and random stalls on
// both handshakes. Every report byte is checked against an in-bench
// prediction of the header and payload stream.
// ----------------------------------------------------------------------------
module tb_image_report_chunker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ircc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 310;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
        logic              cend;
        logic              iend;
        logic              last;
    } report_byte_t;

    typedef enum logic {ROW_REG, ROW_BYTE} row_kind_e;
    typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_ONE} row_exp_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        row_exp_e              how;
        logic                  cend;
        logic                  iend;
    } row_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_image_byte = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [BYTE_W-1:0]     m_out_byte;
    logic                  m_report_start;
    logic                  m_chunk_end;
    logic                  m_image_end;
    logic                  m_run_last;

    // predicted chunker state and registers
    logic [KEY_W-1:0]  key_reg   = '0;
    logic [SIZE_W-1:0] size_reg  = '0;
    logic [SIZE_W-1:0] img_off   = '0;
    logic [PAGE_W-1:0] page_cnt  = '0;
    logic [LEN_W-1:0]  chunk_pos = '0;

    report_byte_t report_q[$];
    int errors      = 0;
    int checked     = 0;
    int bytes_taken = 0;
    int cycles      = 0;
    int tx_quiet    = 0;
    int rx_quiet    = 0;

    image_report_chunker_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_image_byte   (s_image_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_report_start (m_report_start),
        .m_chunk_end    (m_chunk_end),
        .m_image_end    (m_image_end),
        .m_run_last     (m_run_last)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic report_byte_t mk_report(input logic [BYTE_W-1:0] d, input logic s,
                                               input logic c, input logic i, input logic l);
        report_byte_t rb;
        rb.data  = d;
        rb.start = s;
        rb.cend  = c;
        rb.iend  = i;
        rb.last  = l;
        return rb;
    endfunction

    function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        row_t rw;
        rw.kind = ROW_REG;
        rw.idx  = idx;
        rw.data = data;
        rw.how  = EXP_PRED;
        rw.cend = 1'b0;
        rw.iend = 1'b0;
        return rw;
    endfunction

    function automatic row_t byte_row(input logic [BYTE_W-1:0] b, input row_exp_e how,
                                      input logic c, input logic i);
        row_t rw;
        rw.kind = ROW_BYTE;
        rw.idx  = '0;
        rw.data = {8'd0, b};
        rw.how  = how;
        rw.cend = c;
        rw.iend = i;
        return rw;
    endfunction

    function automatic int draw_gap(inout int quiet);
        if (quiet == 0 && $urandom_range(0, 39) == 0) begin
            quiet = $urandom_range(20, 60);
        end
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic void clear_progress();
        img_off   = '0;
        page_cnt  = '0;
        chunk_pos = '0;
    endfunction

    // Work out the report bytes one image byte causes and advance the state.
    task automatic predict_report(input logic [BYTE_W-1:0] b, input bit keep, output int n);
        report_byte_t res[$];
        int remaining;
        int len;
        bit iend;
        bit cend;
        n = 0;
        if (size_reg == 0 || img_off >= size_reg) begin
            clear_progress();
            return;
        end
        if (chunk_pos == 0) begin
            remaining = int'(size_reg) - int'(img_off);
            len = (remaining > PAYLOAD_BYTES) ? PAYLOAD_BYTES : remaining;
            res.push_back(mk_report(REPORT_ID, 1'b1, 1'b0, 1'b0, 1'b0));
            res.push_back(mk_report(CMD_IMAGE, 1'b0, 1'b0, 1'b0, 1'b0));
            res.push_back(mk_report({4'd0, key_reg}, 1'b0, 1'b0, 1'b0, 1'b0));
            res.push_back(mk_report((int'(img_off) + len >= int'(size_reg)) ? 8'd1 : 8'd0,
                                    1'b0, 1'b0, 1'b0, 1'b0));
            res.push_back(mk_report(8'(len), 1'b0, 1'b0, 1'b0, 1'b0));
            res.push_back(mk_report(8'(len >> 8), 1'b0, 1'b0, 1'b0, 1'b0));
            res.push_back(mk_report(page_cnt[7:0], 1'b0, 1'b0, 1'b0, 1'b0));
            res.push_back(mk_report(page_cnt[15:8], 1'b0, 1'b0, 1'b0, 1'b0));
        end
        iend = (int'(img_off) + 1 >= int'(size_reg));
        cend = iend || (int'(chunk_pos) + 1 >= PAYLOAD_BYTES);
        res.push_back(mk_report(b, 1'b0, cend, iend, 1'b1));
        if (iend) begin
            clear_progress();
        end else begin
            img_off = img_off + 1'b1;
            if (cend) begin
                chunk_pos = '0;
                page_cnt  = page_cnt + 1'b1;
            end else begin
                chunk_pos = chunk_pos + 1'b1;
            end
        end
        n = res.size();
        if (keep) begin
            foreach (res[k]) report_q.push_back(res[k]);
        end
    endtask

    // Hold the sender until every report byte is out and the queue has settled.
    task automatic drain_reports();
        s_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        drain_reports();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TARGET_KEY: key_reg  = data[KEY_W-1:0];
            REG_IMAGE_SIZE: size_reg = data;
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input row_exp_e how,
                             input logic c, input logic i);
        int gap;
        int n;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_image_byte <= b;
        do @(posedge aclk); while (!s_ready);
        predict_report(b, how == EXP_PRED, n);
        if (how == EXP_ONE) report_q.push_back(mk_report(b, 1'b0, c, i, 1'b1));
        if (n > 0) bytes_taken++;
    endtask

    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_gap(rx_quiet);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : check_result
        report_byte_t got;
        report_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_out_byte, m_report_start, m_chunk_end, m_image_end, m_run_last};
            if (report_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected item: byte %h start %b cend %b iend %b last %b",
                         $realtime, got.data, got.start, got.cend, got.iend, got.last);
            end else begin
                want = report_q.pop_front();
                checked++;
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch: expected byte %h start %b cend %b iend %b last %b",
                             $realtime, want.data, want.start, want.cend, want.iend, want.last);
                    $display("%0t:           actual   byte %h start %b cend %b iend %b last %b",
                             $realtime, got.data, got.start, got.cend, got.iend, got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        row_t plan[$];
        int settings;
        int target;
        int remaining;
        int count;
        int mode;
        int pick;
        logic [CFG_DATA_W-1:0] size_pick;

        plan = '{
            byte_row(8'h5A, EXP_NONE, 1'b0, 1'b0),
            reg_row(REG_TARGET_KEY, 16'hFFFF),
            reg_row(REG_IMAGE_SIZE, 16'h0001),
            byte_row(8'hFF, EXP_PRED, 1'b0, 1'b0),
            byte_row(8'h00, EXP_PRED, 1'b0, 1'b0),
            reg_row(REG_TARGET_KEY, 16'h0000),
            reg_row(REG_IMAGE_SIZE, 16'h0003),
            byte_row(8'h00, EXP_PRED, 1'b0, 1'b0),
            byte_row(8'hFF, EXP_ONE,  1'b0, 1'b0),
            byte_row(8'h81, EXP_ONE,  1'b1, 1'b1),
            reg_row(REG_TARGET_KEY, 16'h000E),
            reg_row(REG_IMAGE_SIZE, 16'hFFFF),
            byte_row(8'h7E, EXP_PRED, 1'b0, 1'b0),
            byte_row(8'h01, EXP_ONE,  1'b0, 1'b0),
            byte_row(8'h80, EXP_ONE,  1'b0, 1'b0),
            reg_row(REG_IMAGE_SIZE, 16'h0005),
            byte_row(8'h55, EXP_ONE,  1'b0, 1'b0),
            byte_row(8'hAA, EXP_ONE,  1'b1, 1'b1),
            reg_row(REG_IMAGE_SIZE, 16'hFFFF),
            byte_row(8'h33, EXP_PRED, 1'b0, 1'b0),
            byte_row(8'hCC, EXP_ONE,  1'b0, 1'b0),
            reg_row(REG_IMAGE_SIZE, 16'h0002),
            byte_row(8'h0F, EXP_NONE, 1'b0, 1'b0),
            byte_row(8'hF0, EXP_PRED, 1'b0, 1'b0),
            byte_row(8'h3C, EXP_ONE,  1'b1, 1'b1),
            reg_row(REG_SPARE_A, 16'hFFFF),
            reg_row(REG_SPARE_B, 16'h5A5A),
            byte_row(8'hC3, EXP_PRED, 1'b0, 1'b0),
            byte_row(8'h96, EXP_ONE,  1'b1, 1'b1),
            reg_row(REG_IMAGE_SIZE, 16'h0000),
            byte_row(8'h42, EXP_NONE, 1'b0, 1'b0)
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_REG) begin
                program_reg(plan[r].idx, plan[r].data);
            end else begin
                send_byte(plan[r].data[BYTE_W-1:0], plan[r].how, plan[r].cend, plan[r].iend);
            end
        end

        settings = 0;
        target   = bytes_taken + RANDOM_ITEMS;
        while (settings < 6 || bytes_taken < target) begin
            settings++;
            if ($urandom_range(0, 1) == 0) program_reg(REG_TARGET_KEY, 16'($urandom()));
            if ($urandom_range(0, 7) == 0) begin
                program_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom()));
            end
            mode = $urandom_range(0, 9);
            pick = $urandom_range(0, 19);
            if (pick == 0) size_pick = '0;
            else if (pick == 1) size_pick = 16'($urandom_range(41, 300));
            else size_pick = 16'($urandom_range(1, 40));
            program_reg(REG_IMAGE_SIZE, size_pick);

            // well-formed images mostly; overruns and cut-off images otherwise
            remaining = (size_reg > img_off) ? int'(size_reg) - int'(img_off) : 0;
            if (remaining == 0) count = $urandom_range(1, 3);
            else if (mode == 7) count = remaining + $urandom_range(1, 3);
            else if (mode >= 8) count = $urandom_range(0, remaining - 1);
            else count = remaining;

            repeat (count) begin
                if ($urandom_range(0, 39) == 0) drain_reports();
                send_byte(8'($urandom()), EXP_PRED, 1'b0, 1'b0);
            end
        end

        drain_reports();
        $display("covered %0d image bytes over %0d random settings plus the directed table",
                 bytes_taken, settings);
        $display("checked %0d report bytes, %0d mismatches", checked, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
